// ----- sv/gflp_pkg.sv -----
// Shared types and constants for the graph level peeling block.
// Used by the controller, the datapath and the top level; depends on nothing.

package gflp_pkg;

   // Node index width and node count.
   localparam int IDX_W = 6;
   localparam int NODES = 1 << IDX_W;

   // Level, count and sum widths.
   localparam int LEVEL_W = 7;
   localparam int COUNT_W = 7;
   localparam int SUM_W   = 13;
   localparam int CMD_W   = 2;

   localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET = LEVEL_W'(64);

   // Request command codes.
   localparam logic [CMD_W-1:0] CMD_ADD_NODE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RUN      = 2'd2;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE_WR,
      ST_PEEL,
      ST_PEEL_TAIL,
      ST_LEVEL_END,
      ST_EMIT_EMPTY,
      ST_EMIT_SCAN,
      ST_EMIT_LOAD,
      ST_CLEAR
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic add_node;
      logic edge_capture;
      logic edge_wr;
      logic run_start;
      logic cnt_clr;
      logic cnt_inc;
      logic peel_issue;
      logic level_end;
      logic level_next;
      logic emit_rd;
      logic out_load;
      logic out_empty;
      logic clear_wr;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cnt_last;
      logic present_cur;
      logic later_present;
      logic out_free;
      logic graph_empty;
      logic peel_more;
   } ctl_status_type;

endpackage

// ----- sv/gflp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.

module gflp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/gflp_ctrl.sv -----
// Controller state machine for the graph level peeling block.
// Depends on gflp_pkg for the state type and the command and status structs.

module gflp_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [gflp_pkg::CMD_W-1:0]  req_command,
   input  gflp_pkg::ctl_status_type    status,
   output gflp_pkg::ctl_cmd_type       cmd
);

   gflp_pkg::state_type state_ff, state_in;

   // State register; reset starts with a clearing pass over the edge store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gflp_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         gflp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_command)
                  gflp_pkg::CMD_ADD_NODE: begin
                     cmd.add_node = 1'b1;
                  end
                  gflp_pkg::CMD_ADD_EDGE: begin
                     cmd.edge_capture = 1'b1;
                     state_in         = gflp_pkg::ST_EDGE_WR;
                  end
                  gflp_pkg::CMD_RUN: begin
                     cmd.run_start = 1'b1;
                     cmd.cnt_clr   = 1'b1;
                     state_in      = gflp_pkg::ST_PEEL;
                  end
                  default: begin
                     // Unused command: dropped without effect.
                  end
               endcase
            end
         end
         gflp_pkg::ST_EDGE_WR: begin
            cmd.edge_wr = 1'b1;
            state_in    = gflp_pkg::ST_IDLE;
         end
         gflp_pkg::ST_PEEL: begin
            // Issue one adjacency row read per cycle.
            cmd.peel_issue = 1'b1;
            cmd.cnt_inc    = 1'b1;
            if (status.cnt_last) begin
               state_in = gflp_pkg::ST_PEEL_TAIL;
            end
         end
         gflp_pkg::ST_PEEL_TAIL: begin
            // The last row of the level is checked in this cycle.
            state_in = gflp_pkg::ST_LEVEL_END;
         end
         gflp_pkg::ST_LEVEL_END: begin
            cmd.level_end = 1'b1;
            if (status.peel_more) begin
               cmd.level_next = 1'b1;
               state_in       = gflp_pkg::ST_PEEL;
            end else if (status.graph_empty) begin
               state_in = gflp_pkg::ST_EMIT_EMPTY;
            end else begin
               state_in = gflp_pkg::ST_EMIT_SCAN;
            end
         end
         gflp_pkg::ST_EMIT_EMPTY: begin
            if (status.out_free) begin
               cmd.out_empty = 1'b1;
               state_in      = gflp_pkg::ST_CLEAR;
            end
         end
         gflp_pkg::ST_EMIT_SCAN: begin
            // Walk the indexes until a present node is found.
            if (status.present_cur) begin
               cmd.emit_rd = 1'b1;
               state_in    = gflp_pkg::ST_EMIT_LOAD;
            end else begin
               cmd.cnt_inc = 1'b1;
               if (status.cnt_last) begin
                  state_in = gflp_pkg::ST_CLEAR;
               end
            end
         end
         gflp_pkg::ST_EMIT_LOAD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.later_present) begin
                  cmd.cnt_inc = 1'b1;
                  state_in    = gflp_pkg::ST_EMIT_SCAN;
               end else begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = gflp_pkg::ST_CLEAR;
               end
            end
         end
         gflp_pkg::ST_CLEAR: begin
            // Zero one adjacency row per cycle.
            cmd.clear_wr = 1'b1;
            cmd.cnt_inc  = 1'b1;
            if (status.cnt_last) begin
               state_in = gflp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gflp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- sv/gflp_datapath.sv -----
// Datapath of the graph level peeling block: node masks, the adjacency and
// level memories, run totals, the configuration register and the output register.
// Depends on gflp_pkg and gflp_ram.

module gflp_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  gflp_pkg::ctl_cmd_type         cmd,
   output gflp_pkg::ctl_status_type      status,
   input  logic [gflp_pkg::IDX_W-1:0]    req_node_a,
   input  logic [gflp_pkg::IDX_W-1:0]    req_node_b,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gflp_pkg::LEVEL_W-1:0]  csr_max_level,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_node_valid,
   output logic [gflp_pkg::IDX_W-1:0]    rsp_node_index,
   output logic [gflp_pkg::LEVEL_W-1:0]  rsp_score,
   output logic                          rsp_scored,
   output logic [gflp_pkg::COUNT_W-1:0]  rsp_scored_count,
   output logic [gflp_pkg::SUM_W-1:0]    rsp_score_sum,
   output logic                          rsp_last
);

   // Control state, cleared by reset; the level limit resets to MAX_LEVEL_RESET.
   logic [gflp_pkg::NODES-1:0]   present_ff, present_in;
   logic [gflp_pkg::NODES-1:0]   scored_ff, scored_in;
   logic [gflp_pkg::NODES-1:0]   hit_ff, hit_in;
   logic [gflp_pkg::IDX_W-1:0]   cnt_ff, cnt_in;
   logic [gflp_pkg::COUNT_W-1:0] present_cnt_ff, present_cnt_in;
   logic [gflp_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic                         found_ff, found_in;
   logic [gflp_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [gflp_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic                         eval_vld_ff, eval_vld_in;
   logic [gflp_pkg::LEVEL_W-1:0] max_level_ff, max_level_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [gflp_pkg::IDX_W-1:0]   eval_idx_ff, eval_idx_in;
   logic [gflp_pkg::IDX_W-1:0]   edge_a_ff, edge_a_in;
   logic [gflp_pkg::IDX_W-1:0]   edge_b_ff, edge_b_in;
   logic                         rsp_node_valid_ff, rsp_node_valid_in;
   logic [gflp_pkg::IDX_W-1:0]   rsp_node_index_ff, rsp_node_index_in;
   logic [gflp_pkg::LEVEL_W-1:0] rsp_score_ff, rsp_score_in;
   logic                         rsp_scored_ff, rsp_scored_in;
   logic [gflp_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [gflp_pkg::SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic                         rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic                         adj_wr_en;
   logic [gflp_pkg::IDX_W-1:0]   adj_wr_addr;
   logic [gflp_pkg::NODES-1:0]   adj_wr_data;
   logic [gflp_pkg::IDX_W-1:0]   adj_rd_addr;
   logic [gflp_pkg::NODES-1:0]   adj_rd_data;
   logic [gflp_pkg::LEVEL_W-1:0] lvl_rd_data;

   logic                         peel_hit;
   logic [gflp_pkg::LEVEL_W-1:0] limit;
   logic [gflp_pkg::NODES-1:0]   above_cnt;
   logic [gflp_pkg::NODES-1:0]   target_bit;

   // Adjacency rows: one row per source node, one bit per target.
   gflp_ram #(
      .WIDTH (gflp_pkg::NODES),
      .DEPTH (gflp_pkg::NODES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_wr_en),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data),
      .rd_en   (1'b1),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data)
   );

   // Peel level per node, written once when the node peels.
   gflp_ram #(
      .WIDTH (gflp_pkg::LEVEL_W),
      .DEPTH (gflp_pkg::NODES)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (peel_hit),
      .wr_addr (eval_idx_ff),
      .wr_data (level_ff),
      .rd_en   (cmd.emit_rd),
      .rd_addr (cnt_ff),
      .rd_data (lvl_rd_data)
   );

   // Edge insert is a read-modify-write of the source row; clear writes zeros.
   assign target_bit  = {{(gflp_pkg::NODES-1){1'b0}}, 1'b1} << edge_b_ff;
   assign adj_rd_addr = cmd.peel_issue ? cnt_ff : req_node_a;
   assign adj_wr_en   = cmd.edge_wr | cmd.clear_wr;
   assign adj_wr_addr = cmd.edge_wr ? edge_a_ff : cnt_ff;
   assign adj_wr_data = cmd.edge_wr ? (adj_rd_data | target_bit) : '0;

   // A node peels when it is present, unscored, and every target is scored.
   assign peel_hit = eval_vld_ff & present_ff[eval_idx_ff] & ~scored_ff[eval_idx_ff]
                     & ~|(adj_rd_data & ~scored_ff);

   // Level limit is the register clipped to the present node count.
   assign limit = (max_level_ff > present_cnt_ff) ? present_cnt_ff : max_level_ff;

   // Indexes strictly above the scan position.
   always_comb begin
      for (int k = 0; k < gflp_pkg::NODES; k++) begin
         above_cnt[k] = (gflp_pkg::IDX_W'(k) > cnt_ff);
      end
   end

   // Status to the controller.
   always_comb begin
      status.cnt_last      = &cnt_ff;
      status.present_cur   = present_ff[cnt_ff];
      status.later_present = |(present_ff & above_cnt);
      status.out_free      = ~rsp_valid_ff | rsp_ready;
      status.graph_empty   = (present_cnt_ff == '0);
      status.peel_more     = (count_ff != present_cnt_ff) & found_ff & (level_ff < limit);
   end

   // Next-state logic.
   always_comb begin
      present_in        = present_ff;
      scored_in         = scored_ff;
      hit_in            = hit_ff;
      cnt_in            = cnt_ff;
      present_cnt_in    = present_cnt_ff;
      level_in          = level_ff;
      found_in          = found_ff;
      count_in          = count_ff;
      sum_in            = sum_ff;
      eval_vld_in       = cmd.peel_issue;
      eval_idx_in       = cnt_ff;
      max_level_in      = max_level_ff;
      rsp_valid_in      = rsp_valid_ff;
      edge_a_in         = edge_a_ff;
      edge_b_in         = edge_b_ff;
      rsp_node_valid_in = rsp_node_valid_ff;
      rsp_node_index_in = rsp_node_index_ff;
      rsp_score_in      = rsp_score_ff;
      rsp_scored_in     = rsp_scored_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_sum_in        = rsp_sum_ff;
      rsp_last_in       = rsp_last_ff;

      // Configuration write.
      if (csr_valid) begin
         max_level_in = csr_max_level;
      end

      // Node insert counts each node once.
      if (cmd.add_node && !present_ff[req_node_a]) begin
         present_in[req_node_a] = 1'b1;
         present_cnt_in         = present_cnt_ff + 1'b1;
      end

      if (cmd.edge_capture) begin
         edge_a_in = req_node_a;
         edge_b_in = req_node_b;
      end

      // Shared index counter.
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end

      // Run start clears the totals and the level.
      if (cmd.run_start) begin
         level_in = '0;
         found_in = 1'b0;
         count_in = '0;
         sum_in   = '0;
         hit_in   = '0;
      end

      // Record a peeled node for this level.
      if (peel_hit) begin
         hit_in[eval_idx_ff] = 1'b1;
         found_in            = 1'b1;
         count_in            = count_ff + 1'b1;
         sum_in              = sum_ff + gflp_pkg::SUM_W'(level_ff);
      end

      // End of level: the level's hits become scored together.
      if (cmd.level_end) begin
         scored_in = scored_ff | hit_ff;
         hit_in    = '0;
      end
      if (cmd.level_next) begin
         level_in = level_ff + 1'b1;
         found_in = 1'b0;
      end

      // Clearing pass empties the graph.
      if (cmd.clear_wr) begin
         present_in     = '0;
         scored_in      = '0;
         present_cnt_in = '0;
      end

      // Output register: load a new beat or drop the taken one.
      if (cmd.out_load) begin
         rsp_valid_in      = 1'b1;
         rsp_node_valid_in = 1'b1;
         rsp_node_index_in = cnt_ff;
         rsp_scored_in     = scored_ff[cnt_ff];
         rsp_score_in      = scored_ff[cnt_ff] ? lvl_rd_data : '0;
         rsp_count_in      = count_ff;
         rsp_sum_in        = sum_ff;
         rsp_last_in       = ~status.later_present;
      end else if (cmd.out_empty) begin
         rsp_valid_in      = 1'b1;
         rsp_node_valid_in = 1'b0;
         rsp_node_index_in = '0;
         rsp_scored_in     = 1'b0;
         rsp_score_in      = '0;
         rsp_count_in      = '0;
         rsp_sum_in        = '0;
         rsp_last_in       = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff     <= '0;
         scored_ff      <= '0;
         hit_ff         <= '0;
         cnt_ff         <= '0;
         present_cnt_ff <= '0;
         level_ff       <= '0;
         found_ff       <= 1'b0;
         count_ff       <= '0;
         sum_ff         <= '0;
         eval_vld_ff    <= 1'b0;
         max_level_ff   <= gflp_pkg::MAX_LEVEL_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         present_ff     <= present_in;
         scored_ff      <= scored_in;
         hit_ff         <= hit_in;
         cnt_ff         <= cnt_in;
         present_cnt_ff <= present_cnt_in;
         level_ff       <= level_in;
         found_ff       <= found_in;
         count_ff       <= count_in;
         sum_ff         <= sum_in;
         eval_vld_ff    <= eval_vld_in;
         max_level_ff   <= max_level_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      eval_idx_ff       <= eval_idx_in;
      edge_a_ff         <= edge_a_in;
      edge_b_ff         <= edge_b_in;
      rsp_node_valid_ff <= rsp_node_valid_in;
      rsp_node_index_ff <= rsp_node_index_in;
      rsp_score_ff      <= rsp_score_in;
      rsp_scored_ff     <= rsp_scored_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_sum_ff        <= rsp_sum_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_node_valid   = rsp_node_valid_ff;
   assign rsp_node_index   = rsp_node_index_ff;
   assign rsp_score        = rsp_score_ff;
   assign rsp_scored       = rsp_scored_ff;
   assign rsp_scored_count = rsp_count_ff;
   assign rsp_score_sum    = rsp_sum_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ----- sv/graph_flow_level_peeling_top.sv -----
// Graph level peeling: loads nodes and edges of a 64-node directed graph, then on a
// run command assigns each node the level at which all its edge targets were already
// scored, up to the level limit, and streams one beat per present node in ascending
// index order. An add node is taken in the idle state; an add edge reads and then
// writes the source row in the adjacency memory. Every level of a run reads all 64
// adjacency rows through the single read port. Emitting scans the indexes up to the
// highest present node and loads one beat per present node, or a single beat for an
// empty graph, and waits while the result side stalls. A clearing pass over the
// adjacency memory ends every run. The same clearing pass runs after reset before
// the first item is accepted.
// Top level; depends on gflp_pkg, gflp_ctrl, gflp_datapath and gflp_ram.

module graph_flow_level_peeling_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gflp_pkg::CMD_W-1:0]    req_command,
   input  logic [gflp_pkg::IDX_W-1:0]    req_node_a,
   input  logic [gflp_pkg::IDX_W-1:0]    req_node_b,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_node_valid,
   output logic [gflp_pkg::IDX_W-1:0]    rsp_node_index,
   output logic [gflp_pkg::LEVEL_W-1:0]  rsp_score,
   output logic                          rsp_scored,
   output logic [gflp_pkg::COUNT_W-1:0]  rsp_scored_count,
   output logic [gflp_pkg::SUM_W-1:0]    rsp_score_sum,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gflp_pkg::LEVEL_W-1:0]  csr_max_level
);

   gflp_pkg::ctl_cmd_type    cmd;
   gflp_pkg::ctl_status_type status;

   // Sequencer for load, peel, emit and clear phases.
   gflp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd)
   );

   // Storage, peel check, totals and output register.
   gflp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_node_a       (req_node_a),
      .req_node_b       (req_node_b),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_level    (csr_max_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_node_valid   (rsp_node_valid),
      .rsp_node_index   (rsp_node_index),
      .rsp_score        (rsp_score),
      .rsp_scored       (rsp_scored),
      .rsp_scored_count (rsp_scored_count),
      .rsp_score_sum    (rsp_score_sum),
      .rsp_last         (rsp_last)
   );

endmodule

// ----- bench/gflp_peel_checker.sv -----
// Checker for the graph level peeling block: watches the request, result and csr channels,
// keeps its own copy of the graph and level limit, and predicts every result beat.
// Depends on gflp_pkg for widths, command codes and the level limit reset value.

module gflp_peel_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [gflp_pkg::CMD_W-1:0]    req_command,
   input  logic [gflp_pkg::IDX_W-1:0]    req_node_a,
   input  logic [gflp_pkg::IDX_W-1:0]    req_node_b,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_node_valid,
   input  logic [gflp_pkg::IDX_W-1:0]    rsp_node_index,
   input  logic [gflp_pkg::LEVEL_W-1:0]  rsp_score,
   input  logic                          rsp_scored,
   input  logic [gflp_pkg::COUNT_W-1:0]  rsp_scored_count,
   input  logic [gflp_pkg::SUM_W-1:0]    rsp_score_sum,
   input  logic                          rsp_last,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [gflp_pkg::LEVEL_W-1:0]  csr_max_level,
   input  logic                          wrap_up,
   output int                            fail_count,
   output int                            beats_due
);

   import gflp_pkg::*;

   // One expected result beat.
   typedef struct packed {
      logic               node_valid;
      logic [IDX_W-1:0]   node_index;
      logic [LEVEL_W-1:0] score;
      logic               scored;
      logic [COUNT_W-1:0] scored_count;
      logic [SUM_W-1:0]   score_sum;
      logic               last;
   } peel_beat_type;

   // Shadow copy of the loaded graph and the level limit register.
   logic [NODES-1:0]   edge_rows [NODES];
   logic [NODES-1:0]   present_nodes;
   logic [LEVEL_W-1:0] level_limit;

   peel_beat_type level_beats_due [$];
   int            beat_number;
   bit            leftover_flagged;

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at result %0d: %s is %0d, expected %0d", beat_number, what, got, want);
      fail_count++;
   endtask

   task automatic clear_graph();
      for (int i = 0; i < NODES; i++)
         edge_rows[i] = '0;
      present_nodes = '0;
   endtask

   // Peel the shadow graph level by level and queue one beat per present node.
   task automatic peel_levels();
      logic [NODES-1:0]   scored_mask;
      logic [NODES-1:0]   ripe;
      logic [LEVEL_W-1:0] level_of [NODES];
      int                 node_total;
      int                 remaining;
      int                 found;
      int                 ceiling;
      int                 level;
      int                 total;
      peel_beat_type      beat;

      node_total = $countones(present_nodes);
      ceiling = (int'(level_limit) > node_total) ? node_total : int'(level_limit);
      remaining = node_total;
      level = 0;
      scored_mask = '0;

      // A node is ripe when every edge target was scored at an earlier level.
      do begin
         ripe = '0;
         for (int i = 0; i < NODES; i++)
            if (present_nodes[i] && !scored_mask[i] && ((edge_rows[i] & ~scored_mask) == '0))
               ripe[i] = 1'b1;
         found = $countones(ripe);
         for (int i = 0; i < NODES; i++)
            if (ripe[i])
               level_of[i] = LEVEL_W'(level);
         scored_mask = scored_mask | ripe;
         remaining = remaining - found;
         level++;
      end while (remaining > 0 && found > 0 && level <= ceiling);

      total = 0;
      for (int i = 0; i < NODES; i++)
         if (scored_mask[i])
            total += int'(level_of[i]);

      // Totals ride on every beat; last marks the highest present index.
      for (int i = 0; i < NODES; i++) begin
         if (present_nodes[i]) begin
            beat.node_valid   = 1'b1;
            beat.node_index   = IDX_W'(i);
            beat.score        = scored_mask[i] ? level_of[i] : '0;
            beat.scored       = scored_mask[i];
            beat.scored_count = COUNT_W'($countones(scored_mask));
            beat.score_sum    = SUM_W'(total);
            beat.last         = ((present_nodes >> (i + 1)) == '0);
            level_beats_due.push_back(beat);
         end
      end

      // An empty graph still answers with a single closing beat.
      if (node_total == 0) begin
         beat = '0;
         beat.last = 1'b1;
         level_beats_due.push_back(beat);
      end
   endtask

   // Track configuration, compare result beats, then predict from request beats.
   always @(posedge clock) begin : watch
      peel_beat_type want;

      if (reset) begin
         clear_graph();
         level_limit = MAX_LEVEL_RESET;
         level_beats_due.delete();
         fail_count = 0;
         beat_number = 0;
         leftover_flagged = 1'b0;
      end else begin
         if (csr_valid && csr_ready)
            level_limit = csr_max_level;

         if (rsp_valid && rsp_ready) begin
            if (level_beats_due.size() == 0) begin
               report_mismatch("unexpected result beat, node_index", rsp_node_index, -1);
            end else begin
               want = level_beats_due.pop_front();
               if (rsp_node_valid !== want.node_valid)
                  report_mismatch("node_valid", rsp_node_valid, want.node_valid);
               if (rsp_node_index !== want.node_index)
                  report_mismatch("node_index", rsp_node_index, want.node_index);
               if (rsp_score !== want.score)
                  report_mismatch("score", rsp_score, want.score);
               if (rsp_scored !== want.scored)
                  report_mismatch("scored", rsp_scored, want.scored);
               if (rsp_scored_count !== want.scored_count)
                  report_mismatch("scored_count", rsp_scored_count, want.scored_count);
               if (rsp_score_sum !== want.score_sum)
                  report_mismatch("score_sum", rsp_score_sum, want.score_sum);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
            beat_number++;
         end

         if (req_valid && req_ready) begin
            case (req_command)
               CMD_ADD_NODE: present_nodes[req_node_a] = 1'b1;
               CMD_ADD_EDGE: edge_rows[req_node_a][req_node_b] = 1'b1;
               CMD_RUN: begin
                  peel_levels();
                  clear_graph();
               end
               default: ;
            endcase
         end

         if (wrap_up && !leftover_flagged && level_beats_due.size() != 0) begin
            leftover_flagged = 1'b1;
            report_mismatch("results never delivered", 0, level_beats_due.size());
         end
      end
      beats_due <= level_beats_due.size();
   end

endmodule

// ----- bench/tb_top.sv -----
// Top of the graph level peeling testbench: clock, reset, request and csr stimulus,
// result back-pressure, watchdog and verdict. Depends on gflp_pkg, gflp_peel_checker
// and graph_flow_level_peeling_top.

module tb_top;

   import gflp_pkg::*;

   localparam int WATCHDOG_LIMIT = 30000;
   localparam int HOLD_CYCLES    = 1500;
   localparam int SETTLE_CYCLES  = 150;
   localparam int PHASE_ITEMS    = 35;

   // Command value the block ignores.
   localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

   // One load beat of a graph under construction.
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
   } load_beat_type;

   logic                clock;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command   = '0;
   logic [IDX_W-1:0]    req_node_a    = '0;
   logic [IDX_W-1:0]    req_node_b    = '0;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic                rsp_node_valid;
   logic [IDX_W-1:0]    rsp_node_index;
   logic [LEVEL_W-1:0]  rsp_score;
   logic                rsp_scored;
   logic [COUNT_W-1:0]  rsp_scored_count;
   logic [SUM_W-1:0]    rsp_score_sum;
   logic                rsp_last;
   logic                csr_valid     = 1'b0;
   logic                csr_ready;
   logic [LEVEL_W-1:0]  csr_max_level = '0;

   logic wrap_up        = 1'b0;
   logic hold_kick      = 1'b0;
   logic hold_kick_seen = 1'b0;
   int   hold_left      = 0;
   int   req_idle_pct   = 0;
   int   rsp_stall_pct  = 0;
   int   items_sent     = 0;
   int   quiet_cycles   = 0;
   int   fail_count;
   int   beats_due;

   graph_flow_level_peeling_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_node_a       (req_node_a),
      .req_node_b       (req_node_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_node_valid   (rsp_node_valid),
      .rsp_node_index   (rsp_node_index),
      .rsp_score        (rsp_score),
      .rsp_scored       (rsp_scored),
      .rsp_scored_count (rsp_scored_count),
      .rsp_score_sum    (rsp_score_sum),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_level    (csr_max_level)
   );

   gflp_peel_checker peel_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_node_a       (req_node_a),
      .req_node_b       (req_node_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_node_valid   (rsp_node_valid),
      .rsp_node_index   (rsp_node_index),
      .rsp_score        (rsp_score),
      .rsp_scored       (rsp_scored),
      .rsp_scored_count (rsp_scored_count),
      .rsp_score_sum    (rsp_score_sum),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_level    (csr_max_level),
      .wrap_up          (wrap_up),
      .fail_count       (fail_count),
      .beats_due        (beats_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result back-pressure: random stalls, plus a long hold-off on each kick.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_kick != hold_kick_seen) begin
         hold_kick_seen <= hold_kick;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Offer one request beat, with random idle cycles ahead of it.
   task automatic send_item(input logic [CMD_W-1:0] command, input int a, input int b);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= command;
      req_node_a <= IDX_W'(a);
      req_node_b <= IDX_W'(b);
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (command != CMD_IGNORED)
         items_sent++;
   endtask

   // Stop offering, wait for every expected result, then let the clearing pass finish.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (beats_due != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_max_level(input int level);
      drain_results();
      csr_valid <= 1'b1;
      csr_max_level <= LEVEL_W'(level);
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Build a random graph, load it in shuffled order with some noise, then run it.
   // Most edges point from a later picked node to an earlier one, so levels stack up.
   task automatic build_and_run(input int node_total, input int edge_total);
      int            picked [$];
      load_beat_type loads [$];
      load_beat_type swap;
      int            j;
      int            k;
      int            roll;
      int            src;
      int            dst;

      for (int n = 0; n < node_total; n++) begin
         picked.push_back(node_total == NODES ? n : $urandom_range(0, NODES - 1));
         loads.push_back({CMD_ADD_NODE, IDX_W'(picked[n]), IDX_W'($urandom_range(0, 63))});
      end

      for (int e = 0; e < edge_total; e++) begin
         roll = $urandom_range(0, 99);
         if (picked.size() == 0) begin
            src = $urandom_range(0, 63);
            dst = $urandom_range(0, 63);
         end else begin
            j = $urandom_range(0, picked.size() - 1);
            k = $urandom_range(0, picked.size() - 1);
            if (roll < 80) begin
               if (j < k) begin
                  src = j;
                  j = k;
                  k = src;
               end
               if (j == k && j > 0)
                  k = j - 1;
               src = picked[j];
               dst = picked[k];
            end else if (roll < 90) begin
               // Target may never be added as a node.
               src = picked[j];
               dst = $urandom_range(0, 63);
            end else if (roll < 95) begin
               // Arbitrary pair: cycles and self loops.
               src = picked[j];
               dst = picked[k];
            end else begin
               src = $urandom_range(0, 63);
               dst = picked[k];
            end
         end
         loads.push_back({CMD_ADD_EDGE, IDX_W'(src), IDX_W'(dst)});
      end

      for (int i = loads.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap = loads[i];
         loads[i] = loads[j];
         loads[j] = swap;
      end

      foreach (loads[i]) begin
         if ($urandom_range(0, 99) < 5)
            send_item(CMD_IGNORED, $urandom_range(0, 63), $urandom_range(0, 63));
         send_item(loads[i].command, loads[i].a, loads[i].b);
      end
      send_item(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63));
   endtask

   function automatic int pick_max_level();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 1;
         2: return 2;
         3: return 64;
         default: return $urandom_range(0, 64);
      endcase
   endfunction

   initial begin : stimulus
      int phase_start;
      int size_roll;
      int node_total;

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty run, extreme indices, chain, self loop, absent target,
      // ignored command, duplicates, unexamined source, then level limits 1 and 0.
      write_max_level(64);
      send_item(CMD_RUN, 0, 0);
      send_item(CMD_ADD_NODE, 0, 0);
      send_item(CMD_ADD_NODE, 63, 63);
      send_item(CMD_ADD_NODE, 1, 0);
      send_item(CMD_ADD_NODE, 2, 0);
      send_item(CMD_ADD_NODE, 3, 0);
      send_item(CMD_ADD_EDGE, 1, 2);
      send_item(CMD_ADD_EDGE, 2, 3);
      send_item(CMD_ADD_EDGE, 3, 0);
      send_item(CMD_ADD_EDGE, 63, 63);
      send_item(CMD_ADD_NODE, 5, 0);
      send_item(CMD_ADD_EDGE, 5, 40);
      send_item(CMD_ADD_EDGE, 1, 2);
      send_item(CMD_IGNORED, 63, 63);
      send_item(CMD_ADD_EDGE, 50, 0);
      send_item(CMD_RUN, 63, 63);
      write_max_level(1);
      send_item(CMD_ADD_NODE, 10, 0);
      send_item(CMD_ADD_NODE, 11, 0);
      send_item(CMD_ADD_NODE, 12, 0);
      send_item(CMD_ADD_EDGE, 12, 11);
      send_item(CMD_ADD_EDGE, 11, 10);
      send_item(CMD_RUN, 0, 0);
      write_max_level(0);
      send_item(CMD_ADD_NODE, 20, 0);
      send_item(CMD_ADD_NODE, 21, 0);
      send_item(CMD_ADD_EDGE, 21, 20);
      send_item(CMD_RUN, 0, 0);
      write_max_level(64);

      // Random part in four idling phases.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct = 69;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct = 0;
               rsp_stall_pct = 69;
            end
            default: begin
               req_idle_pct = 30;
               rsp_stall_pct = 30;
            end
         endcase
         phase_start = items_sent;

         if (phase == 0)
            build_and_run(NODES, 16);
         if (phase == 1)
            drain_results();
         if (phase == 2) begin
            // Results back up behind a long hold-off while requests keep coming.
            hold_kick <= ~hold_kick;
            build_and_run(4, 3);
         end

         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 20)
               write_max_level(pick_max_level());
            size_roll = $urandom_range(0, 99);
            if (size_roll < 5)
               node_total = 0;
            else if (size_roll < 85)
               node_total = $urandom_range(1, 8);
            else
               node_total = $urandom_range(9, 20);
            build_and_run(node_total, $urandom_range(0, 2 * node_total + 1));
         end
      end

      drain_results();
      wrap_up <= 1'b1;
      repeat (2) @(negedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
sv/gflp_pkg.sv
sv/gflp_ram.sv
sv/gflp_ctrl.sv
sv/gflp_datapath.sv
sv/graph_flow_level_peeling_top.sv
bench/gflp_peel_checker.sv
bench/tb_top.sv
